// ===== rtl/dltm_pkg.sv =====
// Package for the delta list timer manager.
// Item types, operation and status codes, default sizes. No dependencies.
package dltm_pkg;

	localparam int TIMER_SLOTS_DEF = 8;
	localparam int MAX_RESULTS     = 8;
	localparam int NW              = $clog2(MAX_RESULTS + 1);

	localparam logic [1:0] OP_CREATE  = 2'd0;
	localparam logic [1:0] OP_RESTART = 2'd1;
	localparam logic [1:0] OP_DESTROY = 2'd2;
	localparam logic [1:0] OP_TICK    = 2'd3;

	localparam logic [2:0] ST_CREATED = 3'd0;
	localparam logic [2:0] ST_NOFREE  = 3'd1;
	localparam logic [2:0] ST_EXPIRED = 3'd2;
	localparam logic [2:0] ST_DONE    = 3'd3;
	localparam logic [2:0] ST_BAD     = 3'd4;

	typedef struct packed {
		logic [1:0]  operation;
		logic [2:0]  target_slot;
		logic [31:0] period_ticks;
	} cmd_t;

	typedef struct packed {
		logic [2:0] status;
		logic [2:0] result_slot;
		logic       last;
	} rsp_t;

endpackage

// ===== rtl/dltm_chan_if.sv =====
// Valid/ready channel carrying one item per handshake.
// Payload type is a parameter; used with dltm_pkg types.
interface dltm_chan_if #(parameter type item_t = logic);
	logic  valid;
	logic  ready;
	item_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/delta_list_timer_manager_core.sv =====
// Delta list timer manager: up to TIMER_SLOTS one-shot timers in a delta-ordered list.
// Depends on dltm_pkg and dltm_chan_if.
//
// One item at a time; cmd.ready is high only between items. Every list step goes through
// a single read port on the delta and next stores and one shared 32-bit add/subtract unit,
// one list entry per cycle. Create walks up to TIMER_SLOTS entries, links the slot and
// fixes the next delta. Restart unlinks the slot when queued, then inserts it as Create
// does. Destroy unlinks first when queued. Tick decrements the head delta, then takes
// expired timers off the head, up to eight expiries per tick. Results go out through a
// registered output; a stalled consumer holds the sequencer. No clearing pass after reset.
module delta_list_timer_manager_core #(
	parameter int TIMER_SLOTS = dltm_pkg::TIMER_SLOTS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	dltm_chan_if.sink   cmd,
	dltm_chan_if.source rsp
);

	localparam int IW = $clog2(TIMER_SLOTS + 1);
	localparam int AW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
	localparam logic [IW-1:0] NIL = IW'(TIMER_SLOTS);

	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_UL_WALK = 4'd1;
	localparam logic [3:0] S_UL_FIX  = 4'd2;
	localparam logic [3:0] S_UL_ADD  = 4'd3;
	localparam logic [3:0] S_IN_WALK = 4'd4;
	localparam logic [3:0] S_IN_LINK = 4'd5;
	localparam logic [3:0] S_IN_FIX  = 4'd6;
	localparam logic [3:0] S_RESP    = 4'd7;
	localparam logic [3:0] S_TK_DEC  = 4'd8;
	localparam logic [3:0] S_TK_EXP  = 4'd9;

	logic [31:0]   period_q [TIMER_SLOTS];
	logic [31:0]   delta_q  [TIMER_SLOTS];
	logic [IW-1:0] next_q   [TIMER_SLOTS];

	logic [3:0]             state_q;
	logic [IW-1:0]          head_q;
	logic [TIMER_SLOTS-1:0] alloc_q;
	logic [TIMER_SLOTS-1:0] queued_q;
	logic                   rsp_valid_q;
	dltm_pkg::rsp_t         rsp_q;
	logic [dltm_pkg::NW-1:0] n_q;
	logic                   pend_v_q;
	logic [IW-1:0]          pend_q;

	logic [IW-1:0] cur_q, prev_q, tgt_q, nx_q, steps_q;
	logic [31:0]   rem_q, tmp_q;
	logic          restart_q;
	logic [2:0]    rs_status_q, rs_slot_q;

	logic [IW-1:0] d_addr, n_addr, free_idx, ctgt;
	logic [31:0]   d_rd;
	logic [IW-1:0] n_rd;
	logic          free_found, out_free, accept, walk_more, exp_hit, tgt_ok;

	logic [31:0]   alu_a, alu_b;
	logic          alu_sub;
	logic [32:0]   alu_y;

	logic          d_we, n_we, p_we;
	logic [IW-1:0] d_wa, n_wa, p_wa;
	logic [31:0]   d_wd, p_wd;
	logic [IW-1:0] n_wd;

	assign cmd.ready = (state_q == S_IDLE);
	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_q;
	assign accept    = cmd.valid && (state_q == S_IDLE);
	assign out_free  = !rsp_valid_q || rsp.ready;
	assign ctgt      = IW'(cmd.data.target_slot);
	assign tgt_ok    = int'(cmd.data.target_slot) < TIMER_SLOTS;

	always_comb begin
		free_found = 1'b0;
		free_idx   = NIL;
		for (int i = TIMER_SLOTS - 1; i >= 0; i--) begin
			if (!alloc_q[i]) begin
				free_found = 1'b1;
				free_idx   = IW'(i);
			end
		end
	end

	always_comb begin
		d_addr = NIL;
		n_addr = NIL;
		case (state_q)
			S_UL_WALK: n_addr = cur_q;
			S_UL_FIX: begin
				d_addr = tgt_q;
				n_addr = tgt_q;
			end
			S_UL_ADD: d_addr = nx_q;
			S_IN_WALK: begin
				d_addr = cur_q;
				n_addr = cur_q;
			end
			S_IN_FIX: d_addr = cur_q;
			S_TK_DEC, S_TK_EXP: begin
				d_addr = head_q;
				n_addr = head_q;
			end
			default: ;
		endcase
	end

	assign d_rd = (d_addr < NIL) ? delta_q[d_addr[AW-1:0]] : '0;
	assign n_rd = (n_addr < NIL) ? next_q[n_addr[AW-1:0]] : NIL;

	// shared adder; on subtract, carry out set means no borrow
	always_comb begin
		alu_a   = d_rd;
		alu_b   = '0;
		alu_sub = 1'b1;
		case (state_q)
			S_UL_ADD: begin
				alu_b   = tmp_q;
				alu_sub = 1'b0;
			end
			S_IN_WALK: begin
				alu_a = rem_q;
				alu_b = d_rd;
			end
			S_IN_FIX: alu_b = rem_q;
			S_TK_DEC: alu_b = 32'd1;
			default: ;
		endcase
	end

	assign alu_y = {1'b0, alu_a} + {1'b0, alu_b ^ {32{alu_sub}}} + {32'd0, alu_sub};

	assign walk_more = (cur_q < NIL) && alu_y[32] && (alu_y[31:0] != 32'd0)
		&& (steps_q < NIL);
	assign exp_hit   = (n_q < dltm_pkg::NW'(dltm_pkg::MAX_RESULTS)) && (head_q < NIL)
		&& (d_rd == 32'd0);

	always_comb begin
		d_we = 1'b0; d_wa = NIL; d_wd = '0;
		n_we = 1'b0; n_wa = NIL; n_wd = NIL;
		p_we = 1'b0; p_wa = NIL; p_wd = '0;
		case (state_q)
			S_IDLE: begin
				if (accept && cmd.data.operation == dltm_pkg::OP_CREATE
						&& cmd.data.period_ticks != 32'd0 && free_found) begin
					p_we = 1'b1; p_wa = free_idx; p_wd = cmd.data.period_ticks;
				end
			end
			S_UL_FIX: begin
				if (prev_q != NIL) begin
					n_we = 1'b1; n_wa = prev_q; n_wd = n_rd;
				end
			end
			S_UL_ADD: begin
				if (nx_q < NIL) begin
					d_we = 1'b1; d_wa = nx_q; d_wd = alu_y[31:0];
				end
			end
			S_IN_WALK: begin
				if (!walk_more) begin
					n_we = 1'b1; n_wa = tgt_q; n_wd = cur_q;
				end
			end
			S_IN_LINK: begin
				d_we = 1'b1; d_wa = tgt_q; d_wd = rem_q;
				if (prev_q != NIL) begin
					n_we = 1'b1; n_wa = prev_q; n_wd = tgt_q;
				end
			end
			S_IN_FIX: begin
				if (cur_q < NIL) begin
					d_we = 1'b1; d_wa = cur_q; d_wd = alu_y[31:0];
				end
			end
			S_TK_DEC: begin
				if (alu_y[32]) begin
					d_we = 1'b1; d_wa = head_q; d_wd = alu_y[31:0];
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (d_we) delta_q[d_wa[AW-1:0]] <= d_wd;
		if (n_we) next_q[n_wa[AW-1:0]] <= n_wd;
		if (p_we) period_q[p_wa[AW-1:0]] <= p_wd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= NIL;
			alloc_q     <= '0;
			queued_q    <= '0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
			n_q         <= '0;
			pend_v_q    <= 1'b0;
			pend_q      <= NIL;
			cur_q       <= NIL;
			prev_q      <= NIL;
			tgt_q       <= NIL;
			nx_q        <= NIL;
			steps_q     <= '0;
			rem_q       <= '0;
			tmp_q       <= '0;
			restart_q   <= 1'b0;
			rs_status_q <= '0;
			rs_slot_q   <= '0;
		end else begin
			if (rsp.ready) rsp_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						cur_q     <= head_q;
						prev_q    <= NIL;
						steps_q   <= '0;
						restart_q <= (cmd.data.operation == dltm_pkg::OP_RESTART);
						rs_slot_q <= cmd.data.target_slot;
						tgt_q     <= ctgt;
						case (cmd.data.operation)
							dltm_pkg::OP_CREATE: begin
								rs_slot_q <= '0;
								state_q   <= S_RESP;
								if (cmd.data.period_ticks == 32'd0) begin
									rs_status_q <= dltm_pkg::ST_BAD;
								end else if (!free_found) begin
									rs_status_q <= dltm_pkg::ST_NOFREE;
								end else begin
									rs_status_q <= dltm_pkg::ST_CREATED;
									rs_slot_q   <= 3'(free_idx);
									tgt_q       <= free_idx;
									rem_q       <= cmd.data.period_ticks;
									alloc_q[free_idx[AW-1:0]] <= 1'b1;
									state_q     <= S_IN_WALK;
								end
							end
							dltm_pkg::OP_RESTART: begin
								rs_status_q <= dltm_pkg::ST_DONE;
								if (!tgt_ok || !alloc_q[ctgt[AW-1:0]]) begin
									rs_status_q <= dltm_pkg::ST_BAD;
									state_q     <= S_RESP;
								end else begin
									rem_q   <= period_q[ctgt[AW-1:0]];
									state_q <= queued_q[ctgt[AW-1:0]] ? S_UL_WALK : S_IN_WALK;
								end
							end
							dltm_pkg::OP_DESTROY: begin
								rs_status_q <= dltm_pkg::ST_DONE;
								if (!tgt_ok) begin
									rs_status_q <= dltm_pkg::ST_BAD;
									state_q     <= S_RESP;
								end else if (queued_q[ctgt[AW-1:0]]) begin
									state_q <= S_UL_WALK;
								end else begin
									alloc_q[ctgt[AW-1:0]] <= 1'b0;
									state_q <= S_RESP;
								end
							end
							default: begin
								n_q      <= '0;
								pend_v_q <= 1'b0;
								if (head_q != NIL) state_q <= S_TK_DEC;
							end
						endcase
					end
				end
				S_UL_WALK: begin
					if (cur_q == tgt_q) begin
						state_q <= S_UL_FIX;
					end else if (cur_q >= NIL || steps_q == NIL) begin
						nx_q    <= NIL;
						state_q <= S_UL_ADD;
					end else begin
						prev_q  <= cur_q;
						cur_q   <= n_rd;
						steps_q <= steps_q + 1'b1;
					end
				end
				S_UL_FIX: begin
					nx_q  <= n_rd;
					tmp_q <= d_rd;
					if (prev_q == NIL) head_q <= n_rd;
					queued_q[tgt_q[AW-1:0]] <= 1'b0;
					state_q <= S_UL_ADD;
				end
				S_UL_ADD: begin
					cur_q   <= head_q;
					prev_q  <= NIL;
					steps_q <= '0;
					if (restart_q) begin
						state_q <= S_IN_WALK;
					end else begin
						alloc_q[tgt_q[AW-1:0]] <= 1'b0;
						state_q <= S_RESP;
					end
				end
				S_IN_WALK: begin
					if (walk_more) begin
						rem_q   <= alu_y[31:0];
						prev_q  <= cur_q;
						cur_q   <= n_rd;
						steps_q <= steps_q + 1'b1;
					end else begin
						state_q <= S_IN_LINK;
					end
				end
				S_IN_LINK: begin
					if (prev_q == NIL) head_q <= tgt_q;
					queued_q[tgt_q[AW-1:0]] <= 1'b1;
					state_q <= S_IN_FIX;
				end
				S_IN_FIX: state_q <= S_RESP;
				S_RESP: begin
					if (out_free) begin
						rsp_valid_q <= 1'b1;
						rsp_q       <= '{status: rs_status_q, result_slot: rs_slot_q, last: 1'b1};
						state_q     <= S_IDLE;
					end
				end
				S_TK_DEC: state_q <= S_TK_EXP;
				S_TK_EXP: begin
					if (exp_hit) begin
						if (!pend_v_q || out_free) begin
							if (pend_v_q) begin
								rsp_valid_q <= 1'b1;
								rsp_q <= '{status: dltm_pkg::ST_EXPIRED, result_slot: 3'(pend_q),
									last: 1'b0};
							end
							pend_q   <= head_q;
							pend_v_q <= 1'b1;
							head_q   <= n_rd;
							queued_q[head_q[AW-1:0]] <= 1'b0;
							n_q      <= n_q + 1'b1;
						end
					end else if (!pend_v_q) begin
						state_q <= S_IDLE;
					end else if (out_free) begin
						rsp_valid_q <= 1'b1;
						rsp_q <= '{status: dltm_pkg::ST_EXPIRED, result_slot: 3'(pend_q),
							last: 1'b1};
						pend_v_q <= 1'b0;
						state_q  <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_queued_alloc: assert property (@(posedge clk) disable iff (!arst_n)
		(queued_q & ~alloc_q) == '0)
		else $error("queued slot not allocated");

	a_head_queued: assert property (@(posedge clk) disable iff (!arst_n)
		(head_q < NIL) |-> queued_q[head_q[AW-1:0]])
		else $error("list head not queued");

	a_exp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= dltm_pkg::NW'(dltm_pkg::MAX_RESULTS))
		else $error("too many expiries in one tick");

	a_pend_exp: assert property (@(posedge clk) disable iff (!arst_n)
		pend_v_q |-> (state_q == S_TK_EXP))
		else $error("pending expiry outside tick");

endmodule

// ===== tb/sv/tb_delta_list_timer_manager_core.sv =====
// Testbench for delta_list_timer_manager_core: directed table then random commands and ticks.
// Responses are checked against an in-bench model of the delta-ordered timer list, or against a row's typed response.
// Depends on dltm_pkg, dltm_chan_if and the core.
module tb_delta_list_timer_manager_core;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SLOTS = 8;
	localparam logic [3:0] NIL = 4'd8;
	localparam int CYCLE_LIMIT = 300000;

	typedef struct {
		dltm_pkg::cmd_t c;
		bit             typed;
		dltm_pkg::rsp_t r;
	} stim_row_t;

	logic clk;
	logic arst_n;
	int   errors;
	int   cycles;
	bit   tx_burst, rx_burst;

	dltm_chan_if #(.item_t(dltm_pkg::cmd_t)) cmd_ch ();
	dltm_chan_if #(.item_t(dltm_pkg::rsp_t)) rsp_ch ();

	delta_list_timer_manager_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_ch.sink),
		.rsp(rsp_ch.source)
	);

	logic [31:0]    tmr_period [SLOTS];
	logic [31:0]    tmr_delta [SLOTS];
	logic [3:0]     tmr_next [SLOTS];
	bit             tmr_queued [SLOTS];
	logic [3:0]     tmr_head;
	dltm_pkg::rsp_t pending_rsps [$];

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		errors++;
	endtask

	task automatic unlink_timer(input int s);
		logic [3:0] prv, cur, nx;
		int steps;
		prv = NIL;
		cur = tmr_head;
		steps = 0;
		if (!tmr_queued[s])
			return;
		while (cur < NIL && cur != s && steps < SLOTS) begin
			prv = cur;
			cur = tmr_next[cur];
			steps++;
		end
		if (cur != s)
			return;
		nx = tmr_next[s];
		if (prv == NIL)
			tmr_head = nx;
		else
			tmr_next[prv] = nx;
		if (nx < NIL)
			tmr_delta[nx] += tmr_delta[s];
		tmr_queued[s] = 0;
		tmr_next[s] = NIL;
	endtask

	task automatic queue_timer(input int s);
		logic [3:0]  prv, cur;
		logic [31:0] rem;
		int steps;
		prv = NIL;
		cur = tmr_head;
		steps = 0;
		rem = tmr_period[s];
		while (cur < NIL && tmr_delta[cur] < rem && steps < SLOTS) begin
			rem -= tmr_delta[cur];
			prv = cur;
			cur = tmr_next[cur];
			steps++;
		end
		if (prv == NIL)
			tmr_head = 4'(s);
		else
			tmr_next[prv] = 4'(s);
		tmr_next[s] = cur;
		tmr_delta[s] = rem;
		if (cur < NIL)
			tmr_delta[cur] -= rem;
		tmr_queued[s] = 1;
	endtask

	task automatic step_timer_list(input dltm_pkg::cmd_t c, output dltm_pkg::rsp_t res [$]);
		dltm_pkg::rsp_t r;
		logic [3:0] h;
		int fs;
		res = {};
		r.last = 1'b1;
		case (c.operation)
			dltm_pkg::OP_CREATE: begin
				fs = -1;
				for (int i = 0; i < SLOTS; i++)
					if (fs < 0 && tmr_period[i] == 0)
						fs = i;
				if (c.period_ticks == 0) begin
					r.status = dltm_pkg::ST_BAD;
					r.result_slot = 3'd0;
				end else if (fs < 0) begin
					r.status = dltm_pkg::ST_NOFREE;
					r.result_slot = 3'd0;
				end else begin
					tmr_period[fs] = c.period_ticks;
					queue_timer(fs);
					r.status = dltm_pkg::ST_CREATED;
					r.result_slot = fs[2:0];
				end
				res.push_back(r);
			end
			dltm_pkg::OP_RESTART: begin
				r.result_slot = c.target_slot;
				if (tmr_period[c.target_slot] == 0) begin
					r.status = dltm_pkg::ST_BAD;
				end else begin
					unlink_timer(int'(c.target_slot));
					queue_timer(int'(c.target_slot));
					r.status = dltm_pkg::ST_DONE;
				end
				res.push_back(r);
			end
			dltm_pkg::OP_DESTROY: begin
				unlink_timer(int'(c.target_slot));
				tmr_period[c.target_slot] = 0;
				r.status = dltm_pkg::ST_DONE;
				r.result_slot = c.target_slot;
				res.push_back(r);
			end
			default: begin
				if (tmr_head < NIL) begin
					if (tmr_delta[tmr_head] > 0)
						tmr_delta[tmr_head] -= 1;
					while (res.size() < dltm_pkg::MAX_RESULTS && tmr_head < NIL
						&& tmr_delta[tmr_head] == 0) begin
						h = tmr_head;
						tmr_head = tmr_next[h];
						tmr_next[h] = NIL;
						tmr_queued[h] = 0;
						r.status = dltm_pkg::ST_EXPIRED;
						r.result_slot = h[2:0];
						r.last = 1'b0;
						res.push_back(r);
					end
					if (res.size() > 0)
						res[res.size() - 1].last = 1'b1;
				end
			end
		endcase
	endtask

	task automatic send_item(input stim_row_t row);
		int gap;
		dltm_pkg::rsp_t res [$];
		if ($urandom_range(0, 29) == 0)
			tx_burst = !tx_burst;
		gap = tx_burst ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.data <= row.c;
		do @(posedge clk); while (!cmd_ch.ready);
		step_timer_list(row.c, res);
		if (row.typed)
			pending_rsps.push_back(row.r);
		else
			foreach (res[i])
				pending_rsps.push_back(res[i]);
	endtask

	function automatic stim_row_t mk(input logic [1:0] op, input logic [2:0] s,
		input logic [31:0] p, input bit typed = 0,
		input logic [2:0] st = dltm_pkg::ST_DONE, input logic [2:0] rs = 3'd0);
		stim_row_t row;
		row.c.operation = op;
		row.c.target_slot = s;
		row.c.period_ticks = p;
		row.typed = typed;
		row.r.status = st;
		row.r.result_slot = rs;
		row.r.last = 1'b1;
		return row;
	endfunction

	initial begin
		int n;
		rsp_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if ($urandom_range(0, 29) == 0)
				rx_burst = !rx_burst;
			n = rx_burst ? 0 : $urandom_range(0, 7);
			if (n > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (!rsp_ch.valid);
			if (pending_rsps.size() == 0) begin
				report_mismatch($sformatf("unexpected response %p", rsp_ch.data));
			end else begin
				dltm_pkg::rsp_t e;
				e = pending_rsps.pop_front();
				if (rsp_ch.data.status !== e.status)
					report_mismatch($sformatf("status %0d, want %0d",
						rsp_ch.data.status, e.status));
				if (rsp_ch.data.result_slot !== e.result_slot)
					report_mismatch($sformatf("slot %0d, want %0d",
						rsp_ch.data.result_slot, e.result_slot));
				if (rsp_ch.data.last !== e.last)
					report_mismatch($sformatf("last %0d, want %0d",
						rsp_ch.data.last, e.last));
			end
		end
	end

	initial begin
		stim_row_t table_rows [$];
		dltm_pkg::cmd_t c;
		int r;
		errors = 0;
		cycles = 0;
		tx_burst = 0;
		rx_burst = 0;
		cmd_ch.valid = 1'b0;
		cmd_ch.data = '0;
		for (int i = 0; i < SLOTS; i++) begin
			tmr_period[i] = 0;
			tmr_queued[i] = 0;
			tmr_next[i] = NIL;
			tmr_delta[i] = 0;
		end
		tmr_head = NIL;
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		table_rows = {
			mk(dltm_pkg::OP_TICK, 3'd0, 32'd0),
			mk(dltm_pkg::OP_CREATE, 3'd7, 32'd0, 1, dltm_pkg::ST_BAD, 3'd0),
			mk(dltm_pkg::OP_RESTART, 3'd5, 32'd9, 1, dltm_pkg::ST_BAD, 3'd5),
			mk(dltm_pkg::OP_DESTROY, 3'd7, 32'd0, 1, dltm_pkg::ST_DONE, 3'd7),
			mk(dltm_pkg::OP_CREATE, 3'd0, 32'd3, 1, dltm_pkg::ST_CREATED, 3'd0),
			mk(dltm_pkg::OP_CREATE, 3'd0, 32'd3),
			mk(dltm_pkg::OP_CREATE, 3'd0, 32'hFFFF_FFFF),
			mk(dltm_pkg::OP_CREATE, 3'd0, 32'd1),
			mk(dltm_pkg::OP_TICK, 3'd0, 32'd0),
			mk(dltm_pkg::OP_RESTART, 3'd0, 32'd0),
			mk(dltm_pkg::OP_DESTROY, 3'd2, 32'd0),
			mk(dltm_pkg::OP_TICK, 3'd0, 32'd0),
			mk(dltm_pkg::OP_TICK, 3'd0, 32'd0),
			mk(dltm_pkg::OP_TICK, 3'd0, 32'd0),
			mk(dltm_pkg::OP_RESTART, 3'd3, 32'd0),
			mk(dltm_pkg::OP_DESTROY, 3'd3, 32'd0),
			mk(dltm_pkg::OP_CREATE, 3'd0, 32'd2),
			mk(dltm_pkg::OP_CREATE, 3'd0, 32'd2),
			mk(dltm_pkg::OP_CREATE, 3'd0, 32'd2),
			mk(dltm_pkg::OP_CREATE, 3'd0, 32'd2),
			mk(dltm_pkg::OP_CREATE, 3'd0, 32'd2),
			mk(dltm_pkg::OP_CREATE, 3'd0, 32'd2),
			mk(dltm_pkg::OP_CREATE, 3'd0, 32'd5, 1, dltm_pkg::ST_NOFREE, 3'd0),
			mk(dltm_pkg::OP_TICK, 3'd0, 32'd0),
			mk(dltm_pkg::OP_TICK, 3'd0, 32'd0)
		};
		foreach (table_rows[i])
			send_item(table_rows[i]);

		for (int k = 0; k < 205; k++) begin
			if (k == 110) begin
				cmd_ch.valid <= 1'b0;
				@(posedge clk);
				while (pending_rsps.size() != 0)
					@(posedge clk);
			end
			r = $urandom_range(0, 99);
			c.target_slot = 3'($urandom_range(0, 7));
			c.period_ticks = $urandom_range(1, 12);
			if (r < 30) begin
				c.operation = dltm_pkg::OP_CREATE;
				case ($urandom_range(0, 9))
					0: c.period_ticks = $urandom();
					1: c.period_ticks = 32'd0;
					default: ;
				endcase
			end else if (r < 70) begin
				c.operation = dltm_pkg::OP_TICK;
				c.period_ticks = $urandom();
			end else if (r < 85) begin
				c.operation = dltm_pkg::OP_RESTART;
			end else begin
				c.operation = dltm_pkg::OP_DESTROY;
			end
			send_item(mk(c.operation, c.target_slot, c.period_ticks));
		end
		cmd_ch.valid <= 1'b0;

		while (pending_rsps.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule
